>>> rtl/ukc_pkg.sv
// ukc_pkg: shared constants and types for the unit-value knapsack counter.
// Field widths, default sizes, register indexes and sequencer handshake structs.
// No dependencies.
package ukc_pkg;

	localparam int CAPACITY_DEF  = 1024;
	localparam int MAX_ITEMS_DEF = 4095;

	localparam int BUDGET_W   = 10;
	localparam int REACH_W    = 9;
	localparam int HEIGHT_W   = 10;
	localparam int COST_W     = 10;
	localparam int COUNT_W    = 12;
	localparam int CFG_DATA_W = 10;
	localparam int CFG_IDX_W  = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BUDGET,
		CFG_CHAIR_HEIGHT,
		CFG_ARM_REACH
	} cfg_reg_t;

	// top -> sequencer
	typedef struct packed {
		logic start;     // input word accepted
		logic eligible;  // height within reach
		logic last;      // closes the set
		logic take;      // output register can load a result
	} ukc_cmd_t;

	// sequencer -> top
	typedef struct packed {
		logic ready;     // idle, can take a word
		logic done;      // result held in res
	} ukc_sts_t;

endpackage

>>> rtl/unit_value_knapsack_counter_core.sv
// unit_value_knapsack_counter_core: largest count of eligible items within a budget.
// An eligible or last word holds the input for a sweep over the table, one table
// entry per cycle through the shared read-modify-write unit on the two-read one-write table;
// a last word then holds it until the output register is free. An ineligible non-last
// word is taken without a sweep. out_valid rises after a last word's sweep ends and the
// output register is free. Reset clears config registers, then a pass zeroes the table.
module unit_value_knapsack_counter_core #(
	parameter int CAPACITY  = ukc_pkg::CAPACITY_DEF,
	parameter int MAX_ITEMS = ukc_pkg::MAX_ITEMS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wen,
	input  logic [ukc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ukc_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [ukc_pkg::HEIGHT_W-1:0]  item_height,
	input  logic [ukc_pkg::COST_W-1:0]    item_cost,
	input  logic                          last_item,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [ukc_pkg::COUNT_W-1:0]   best_count
);
	import ukc_pkg::*;

	localparam int AW = $clog2(CAPACITY);
	localparam int EW = $clog2(MAX_ITEMS + 1);

	logic [BUDGET_W-1:0] budget_q;
	logic [REACH_W-1:0]  chair_height_q;
	logic [REACH_W-1:0]  arm_reach_q;
	logic                out_valid_q;
	logic [COUNT_W-1:0]  best_count_q;

	ukc_cmd_t      seq_cmd;
	ukc_sts_t      seq_sts;
	logic [EW-1:0] seq_res;
	logic [AW-1:0] res_idx;
	logic          in_acc;
	logic          out_free;
	logic          load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			budget_q       <= '0;
			chair_height_q <= '0;
			arm_reach_q    <= '0;
		end else if (cfg_wen) begin
			case (cfg_reg_t'(cfg_index))
				CFG_BUDGET:       budget_q       <= cfg_wdata[BUDGET_W-1:0];
				CFG_CHAIR_HEIGHT: chair_height_q <= cfg_wdata[REACH_W-1:0];
				CFG_ARM_REACH:    arm_reach_q    <= cfg_wdata[REACH_W-1:0];
				default: ;
			endcase
		end
	end

	// budget past the table end reads the top entry
	assign res_idx = (32'(budget_q) >= 32'(CAPACITY)) ? AW'(CAPACITY - 1)
	                                                  : AW'(budget_q);

	assign in_acc   = in_valid && !in_stall;
	assign in_stall = !seq_sts.ready;
	assign out_free = !out_valid_q || !out_stall;
	assign load     = seq_sts.done && out_free;

	assign seq_cmd.start    = in_acc;
	assign seq_cmd.eligible = ({1'b0, item_height}
	                          <= (11'(chair_height_q) + 11'(arm_reach_q)));
	assign seq_cmd.last     = last_item;
	assign seq_cmd.take     = out_free;

	ukc_seq #(
		.CAPACITY  (CAPACITY),
		.MAX_ITEMS (MAX_ITEMS)
	) u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (seq_cmd),
		.cost    (item_cost),
		.res_idx (res_idx),
		.sts     (seq_sts),
		.res     (seq_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			best_count_q <= COUNT_W'(seq_res);
		end
	end

	assign out_valid  = out_valid_q;
	assign best_count = best_count_q;

	// a last word always starts a sweep
	a_last_sweeps: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && last_item |=> in_stall)
		else $error("last word did not start a sweep");

	a_result_loads: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> out_valid && !seq_sts.done)
		else $error("result not moved to output register");

	a_done_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		seq_sts.done |-> in_stall)
		else $error("input open while result pending");

	a_count_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> 32'(best_count) <= 32'(MAX_ITEMS))
		else $error("count above limit");

endmodule

>>> rtl/ukc_mem.sv
// ukc_mem: best-count table, one write port and two registered read ports.
// Uses no package items.
module ukc_mem #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10,
	parameter int EW    = 12
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [EW-1:0] wdata,
	input  logic [AW-1:0] raddr_a,
	input  logic [AW-1:0] raddr_b,
	output logic [EW-1:0] rdata_a,
	output logic [EW-1:0] rdata_b
);

	logic [EW-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

>>> rtl/ukc_seq.sv
// ukc_seq: sweep sequencer and shared read-modify-write unit over the table.
// Depends on ukc_pkg and ukc_mem.
module ukc_seq #(
	parameter int CAPACITY  = ukc_pkg::CAPACITY_DEF,
	parameter int MAX_ITEMS = ukc_pkg::MAX_ITEMS_DEF,
	localparam int AW = $clog2(CAPACITY),
	localparam int EW = $clog2(MAX_ITEMS + 1)
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  ukc_pkg::ukc_cmd_t         cmd,
	input  logic [ukc_pkg::COST_W-1:0] cost,
	input  logic [AW-1:0]             res_idx,
	output ukc_pkg::ukc_sts_t         sts,
	output logic [EW-1:0]             res
);
	import ukc_pkg::*;

	localparam int CW = (AW > COST_W) ? AW : COST_W;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SWEEP,
		ST_DRAIN,
		ST_RESULT
	} state_t;

	state_t            state_q;
	logic [AW-1:0]     c_q;
	logic              elig_q;
	logic              last_q;
	logic [COST_W-1:0] cost_q;
	logic              valid_s1;
	logic              fits_s1;
	logic [AW-1:0]     addr_s1;
	logic [EW-1:0]     res_q;

	logic [CW-1:0] diff;
	logic          fits;
	logic [EW-1:0] rd_a;
	logic [EW-1:0] rd_b;
	logic [EW-1:0] cand;
	logic [EW-1:0] new_val;
	logic          we;
	logic [AW-1:0] waddr;
	logic [EW-1:0] wdata;

	assign diff = CW'(c_q) - CW'(cost_q);
	assign fits = CW'(c_q) >= CW'(cost_q);

	// take-it candidate from the lower entry, saturating
	assign cand    = (rd_b < EW'(MAX_ITEMS)) ? rd_b + 1'b1 : rd_b;
	assign new_val = (elig_q && fits_s1 && cand > rd_a) ? cand : rd_a;

	// last sweep writes zeros: entry c is never read again once written
	always_comb begin
		we    = 1'b0;
		waddr = addr_s1;
		wdata = new_val;
		if (state_q == ST_CLEAR) begin
			we    = 1'b1;
			waddr = c_q;
			wdata = '0;
		end else if (valid_s1) begin
			we = 1'b1;
			if (last_q) begin
				wdata = '0;
			end
		end
	end

	ukc_mem #(
		.DEPTH (CAPACITY),
		.AW    (AW),
		.EW    (EW)
	) u_mem (
		.clk     (clk),
		.we      (we),
		.waddr   (waddr),
		.wdata   (wdata),
		.raddr_a (c_q),
		.raddr_b (diff[AW-1:0]),
		.rdata_a (rd_a),
		.rdata_b (rd_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			c_q      <= AW'(CAPACITY - 1);
			elig_q   <= 1'b0;
			last_q   <= 1'b0;
			valid_s1 <= 1'b0;
			sts      <= '0;
		end else begin
			valid_s1 <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					c_q <= c_q - 1'b1;
					if (c_q == '0) begin
						c_q       <= AW'(CAPACITY - 1);
						state_q   <= ST_IDLE;
						sts.ready <= 1'b1;
					end
				end
				ST_IDLE: begin
					if (cmd.start && (cmd.eligible || cmd.last)) begin
						elig_q    <= cmd.eligible;
						last_q    <= cmd.last;
						state_q   <= ST_SWEEP;
						sts.ready <= 1'b0;
					end
				end
				ST_SWEEP: begin
					valid_s1 <= 1'b1;
					c_q      <= c_q - 1'b1;
					if (c_q == '0) begin
						c_q     <= AW'(CAPACITY - 1);
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (last_q) begin
						state_q  <= ST_RESULT;
						sts.done <= 1'b1;
					end else begin
						state_q   <= ST_IDLE;
						sts.ready <= 1'b1;
					end
				end
				ST_RESULT: begin
					if (cmd.take) begin
						state_q   <= ST_IDLE;
						sts.done  <= 1'b0;
						sts.ready <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_CLEAR;
					c_q     <= AW'(CAPACITY - 1);
					sts     <= '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && cmd.start) begin
			cost_q <= cost;
		end
		fits_s1 <= fits;
		addr_s1 <= c_q;
		// keep the pre-clear value of the budget entry
		if (valid_s1 && addr_s1 == res_idx) begin
			res_q <= new_val;
		end
	end

	assign res = res_q;

endmodule

>>> tb/tb_unit_value_knapsack_counter_core.sv
// Self-checking testbench for unit_value_knapsack_counter_core.
// Drives item words with bursty valid and random output stalls, predicts best counts
// with its own capacity table, and compares each result word. Depends on ukc_pkg.
`timescale 1ns / 1ps

module tb_unit_value_knapsack_counter_core;
	import ukc_pkg::*;

	localparam int TABLE_DEPTH  = CAPACITY_DEF;
	localparam int COUNT_LIMIT  = MAX_ITEMS_DEF;
	localparam int RANDOM_WORDS = 560;
	localparam int PHASES       = 6;
	localparam int GAP_MAX      = 1500;
	localparam int STALL_MAX    = 40;
	localparam int WORD_BUDGET  = RANDOM_WORDS + PHASES * 24 + 25;
	localparam longint CYCLE_LIMIT = 3 * (longint'(WORD_BUDGET) *
		(TABLE_DEPTH + 3 + GAP_MAX + STALL_MAX) + longint'(PHASES + 8) * (2 * TABLE_DEPTH + 16));

	typedef struct {
		bit                  cfg_wr;
		logic [BUDGET_W-1:0] budget_v;
		logic [REACH_W-1:0]  chair_v;
		logic [REACH_W-1:0]  arm_v;
		logic [HEIGHT_W-1:0] height;
		logic [COST_W-1:0]   cost;
		logic                last;
		bit                  typed;
		logic [COUNT_W-1:0]  count;
	} dir_row_t;

	logic                  clk         = 1'b0;
	logic                  arst_n      = 1'b0;
	logic                  cfg_wen     = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index   = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata   = '0;
	logic                  in_valid    = 1'b0;
	logic                  in_stall;
	logic [HEIGHT_W-1:0]   item_height = '0;
	logic [COST_W-1:0]     item_cost   = '0;
	logic                  last_item   = 1'b0;
	logic                  out_valid;
	logic                  out_stall   = 1'b0;
	logic [COUNT_W-1:0]    best_count;

	// predictor state: best count per remaining capacity, plus register copies
	logic [COUNT_W-1:0]  cap_best [TABLE_DEPTH];
	logic [BUDGET_W-1:0] budget_r = '0;
	logic [REACH_W-1:0]  chair_r  = '0;
	logic [REACH_W-1:0]  arm_r    = '0;

	logic [COUNT_W-1:0] pending_counts [$];
	dir_row_t           dir_rows [$];
	int                 errors     = 0;
	int                 burst_left = 0;
	int                 stall_left = 0;
	bit                 stall_now  = 1'b0;
	longint             cycles     = 0;

	unit_value_knapsack_counter_core #(
		.CAPACITY (TABLE_DEPTH),
		.MAX_ITEMS(COUNT_LIMIT)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wen    (cfg_wen),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.item_height(item_height),
		.item_cost  (item_cost),
		.last_item  (last_item),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.best_count (best_count)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic log_mismatch(input string what);
		$display("%0t: %s", $time, what);
		errors++;
	endtask

	// one item through the 0/1 table, top capacity first so an item is used once
	task automatic fold_item(input logic [HEIGHT_W-1:0] h, input logic [COST_W-1:0] c,
			input logic l, output bit has, output logic [COUNT_W-1:0] cnt);
		int cand;
		int idx;
		int cost_i;
		has = 1'b0;
		cnt = '0;
		cost_i = int'(c);
		if (int'(h) <= int'(chair_r) + int'(arm_r)) begin
			for (int k = TABLE_DEPTH - 1; k >= cost_i; k--) begin
				cand = int'(cap_best[k - cost_i]);
				if (cand < COUNT_LIMIT)
					cand++;
				if (cand > int'(cap_best[k]))
					cap_best[k] = COUNT_W'(cand);
			end
		end
		if (l) begin
			idx = (int'(budget_r) >= TABLE_DEPTH) ? TABLE_DEPTH - 1 : int'(budget_r);
			has = 1'b1;
			cnt = cap_best[idx];
			foreach (cap_best[k])
				cap_best[k] = '0;
		end
	endtask

	task automatic send_word(input logic [HEIGHT_W-1:0] h, input logic [COST_W-1:0] c,
			input logic l, input bit typed, input logic [COUNT_W-1:0] typed_cnt);
		int gap;
		bit has;
		logic [COUNT_W-1:0] cnt;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
			gap = ($urandom_range(0, 9) == 0) ? $urandom_range(0, GAP_MAX) : $urandom_range(0, 12);
			if ($urandom_range(0, 4) == 0)
				gap = 0;
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		in_valid    <= 1'b1;
		item_height <= h;
		item_cost   <= c;
		last_item   <= l;
		@(posedge clk);
		while (in_stall !== 1'b0)
			@(posedge clk);
		burst_left--;
		fold_item(h, c, l, has, cnt);
		if (has)
			pending_counts.push_back(typed ? typed_cnt : cnt);
	endtask

	// sender holds off until every result word has come back
	task automatic wait_drain();
		in_valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (pending_counts.size() != 0)
			@(posedge clk);
	endtask

	task automatic apply_settings(input logic [BUDGET_W-1:0] b, input logic [REACH_W-1:0] ch,
			input logic [REACH_W-1:0] ar);
		wait_drain();
		repeat (TABLE_DEPTH + 4) @(posedge clk);
		cfg_wen   <= 1'b1;
		cfg_index <= CFG_BUDGET;
		cfg_wdata <= CFG_DATA_W'(b);
		@(posedge clk);
		budget_r = b;
		cfg_index <= CFG_CHAIR_HEIGHT;
		cfg_wdata <= CFG_DATA_W'(ch);
		@(posedge clk);
		chair_r = ch;
		cfg_index <= CFG_ARM_REACH;
		cfg_wdata <= CFG_DATA_W'(ar);
		@(posedge clk);
		arm_r = ar;
		cfg_wen <= 1'b0;
	endtask

	task automatic add_row(input bit cfg_wr, input int b, input int ch, input int ar,
			input int h, input int c, input bit l, input bit typed, input int cnt);
		dir_row_t r;
		r.cfg_wr   = cfg_wr;
		r.budget_v = BUDGET_W'(b);
		r.chair_v  = REACH_W'(ch);
		r.arm_v    = REACH_W'(ar);
		r.height   = HEIGHT_W'(h);
		r.cost     = COST_W'(c);
		r.last     = l;
		r.typed    = typed;
		r.count    = COUNT_W'(cnt);
		dir_rows.push_back(r);
	endtask

	// sets of random length, heights mostly within reach and some at the reach edge, costs mostly small
	task automatic run_phase(input int n_words);
		int sent;
		int set_len;
		int reach_i;
		logic [HEIGHT_W-1:0] h;
		logic [COST_W-1:0] c;
		sent = 0;
		reach_i = int'(chair_r) + int'(arm_r);
		while (sent < n_words) begin
			set_len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
			for (int p = 0; p < set_len; p++) begin
				if ($urandom_range(0, 59) == 0)
					wait_drain();
				case ($urandom_range(0, 9))
					0: h = HEIGHT_W'(reach_i);
					1: h = HEIGHT_W'(reach_i + 1);
					2: h = '1;
					3: h = '0;
					4, 5: h = HEIGHT_W'($urandom_range(0, 1023));
					default: h = HEIGHT_W'($urandom_range(0, reach_i));
				endcase
				case ($urandom_range(0, 9))
					0: c = '0;
					1: c = '1;
					2: c = COST_W'($urandom);
					3: c = COST_W'(budget_r);
					default: c = COST_W'($urandom_range(0, int'(budget_r) / 4 + 2));
				endcase
				send_word(h, c, p == set_len - 1, 1'b0, '0);
				sent++;
			end
		end
	endtask

	// receiver: long open stretches, short stall runs, short open gaps
	always @(posedge clk) begin
		if (stall_left == 0) begin
			case ($urandom_range(0, 7))
				0: begin
					stall_now  = 1'b0;
					stall_left = $urandom_range(50, 600);
				end
				1, 2, 3: begin
					stall_now  = 1'b1;
					stall_left = $urandom_range(1, STALL_MAX);
				end
				default: begin
					stall_now  = 1'b0;
					stall_left = $urandom_range(1, 6);
				end
			endcase
		end
		stall_left--;
		out_stall <= stall_now;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (pending_counts.size() == 0)
				log_mismatch($sformatf("unexpected result word, best_count %0d", best_count));
			else if (best_count !== pending_counts[0]) begin
				log_mismatch($sformatf("best_count got %0d want %0d", best_count,
					pending_counts[0]));
				void'(pending_counts.pop_front());
			end else
				void'(pending_counts.pop_front());
		end
	end

	initial begin
		foreach (cap_best[k])
			cap_best[k] = '0;

		//      cfg  budget chair arm  height cost last typed count
		add_row(1, 0,    0,   0,   0,    0,    1, 1, 1);  // zero cost fits a zero budget
		add_row(0, 0,    0,   0,   1,    0,    1, 1, 0);  // lone ineligible last: empty set
		add_row(0, 0,    0,   0,   0,    1,    1, 1, 0);  // cost over every usable capacity
		add_row(1, 1023, 511, 511, 1022, 1023, 0, 0, 0);
		add_row(0, 0,    0,   0,   1023, 0,    0, 0, 0);  // max height never in reach
		add_row(0, 0,    0,   0,   0,    0,    1, 1, 2);
		add_row(0, 0,    0,   0,   0,    1023, 0, 0, 0);
		add_row(0, 0,    0,   0,   0,    1023, 1, 1, 1);
		add_row(0, 0,    0,   0,   1022, 512,  0, 0, 0);
		add_row(0, 0,    0,   0,   0,    511,  0, 0, 0);
		add_row(0, 0,    0,   0,   5,    1,    1, 1, 2);
		add_row(0, 0,    0,   0,   100,  10,   0, 0, 0);
		add_row(0, 0,    0,   0,   1023, 0,    1, 1, 1);  // ineligible last closes the set
		add_row(1, 10,   3,   4,   7,    5,    0, 0, 0);
		add_row(0, 0,    0,   0,   8,    0,    0, 0, 0);
		add_row(0, 0,    0,   0,   7,    5,    0, 0, 0);
		add_row(0, 0,    0,   0,   0,    6,    1, 1, 2);
		add_row(1, 511,  256, 255, 511,  300,  0, 0, 0);
		add_row(0, 0,    0,   0,   512,  1,    0, 0, 0);
		add_row(0, 0,    0,   0,   200,  100,  0, 0, 0);
		add_row(0, 0,    0,   0,   3,    211,  1, 0, 0);

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i]) begin
			if (dir_rows[i].cfg_wr)
				apply_settings(dir_rows[i].budget_v, dir_rows[i].chair_v, dir_rows[i].arm_v);
			send_word(dir_rows[i].height, dir_rows[i].cost, dir_rows[i].last,
				dir_rows[i].typed, dir_rows[i].count);
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: apply_settings('1, '1, '1);
				1: apply_settings('0, '0, '0);
				2: apply_settings('1, '0, '0);
				3: apply_settings('0, '1, '1);
				default: apply_settings(
					BUDGET_W'(($urandom_range(0, 1) == 0) ? $urandom_range(0, 80) :
						$urandom_range(0, 1023)),
					REACH_W'($urandom_range(0, 511)), REACH_W'($urandom_range(0, 511)));
			endcase
			run_phase(RANDOM_WORDS / PHASES);
		end

		in_valid <= 1'b0;
		while (pending_counts.size() != 0)
			@(posedge clk);
		repeat (TABLE_DEPTH + 8) @(posedge clk);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

>>> unit_value_knapsack_counter_core.f
rtl/ukc_pkg.sv
rtl/ukc_mem.sv
rtl/ukc_seq.sv
rtl/unit_value_knapsack_counter_core.sv
tb/tb_unit_value_knapsack_counter_core.sv
